// ----- hw/rtl/dpb_pkg.sv -----
package dpb_pkg;

    // Frame limits; a pixel at or beyond them maps to the origin
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LIMIT_W    = 17;
    localparam logic [LIMIT_W-1:0] MAX_WIDTH_L  = LIMIT_W'(MAX_WIDTH);
    localparam logic [LIMIT_W-1:0] MAX_HEIGHT_L = LIMIT_W'(MAX_HEIGHT);

    // Field widths
    localparam int DEPTH_W  = 16;
    localparam int PIX_W    = 12;
    localparam int CENTER_W = 16;
    localparam int RECIP_W  = 24;
    localparam int ZFULL_W  = DEPTH_W + RECIP_W;
    localparam int ZQ_W     = 32;
    localparam int MAG_W    = 16;
    localparam int PROD_W   = MAG_W + ZQ_W;
    localparam int HALF_W   = PROD_W / 2;
    localparam int PP_W     = HALF_W + RECIP_W;
    localparam int SUM_W    = PROD_W + RECIP_W;
    localparam int M_W      = SUM_W - 28;
    localparam int COORD_W  = 32;
    localparam int Z_W      = 31;

    // Fixed-point rounding
    localparam int                 ZQ_SHIFT = 8;
    localparam logic [ZFULL_W-1:0] ZQ_RND   = ZFULL_W'(128);
    localparam logic [SUM_W-1:0]   M_RND    = SUM_W'(1) << 27;
    localparam logic [M_W-1:0]     M_POS_LIM = M_W'(32'h7FFF_FFFF);
    localparam logic [M_W-1:0]     M_NEG_LIM = M_W'(32'h8000_0000);
    localparam logic [COORD_W-1:0] COORD_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_NEG_MAX = 32'h8000_0000;
    localparam logic [Z_W-1:0]     Z_MAX = {Z_W{1'b1}};

    // Pipeline depth
    localparam int NUM_STAGES = 5;

    // Configuration map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_INV_FX     = 3'd2,
        CFG_INV_FY     = 3'd3,
        CFG_INV_SCALE  = 3'd4
    } t_cfg_idx;

    localparam logic [CENTER_W-1:0] RST_CENTER_X  = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y  = 16'd3840;
    localparam logic [RECIP_W-1:0]  RST_INV_FX    = 24'd33554;
    localparam logic [RECIP_W-1:0]  RST_INV_FY    = 24'd33554;
    localparam logic [RECIP_W-1:0]  RST_INV_SCALE = 24'd16777;

    // Per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } t_pipe_ctl;

endpackage

// ----- hw/rtl/dpb_pipe_ctl.sv -----
module dpb_pipe_ctl
    import dpb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_ready;
    logic [NUM_STAGES-1:0] n_up_vld;

    // A stage takes new data when it is empty or its successor moves on
    always_comb begin
        n_ready[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_ready[k] = !r_vld[k] || n_ready[k+1];
        end
        n_up_vld[0] = i_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_up_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (n_ready[k]) begin
                    r_vld[k] <= n_up_vld[k];
                end
            end
        end
    end

    assign o_ready   = n_ready[0];
    assign o_valid   = r_vld[NUM_STAGES-1];
    assign o_ctl.ld  = n_ready & n_up_vld;

    // Backpressure only when every stage holds a request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // A stalled first stage keeps its request
    a_hold_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !n_ready[1]) |=> r_vld[0])
        else $error("stalled request dropped in first stage");

    // A result that is not taken stays
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

endmodule

// ----- hw/rtl/dpb_depth.sv -----
module dpb_depth
    import dpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe_ctl           i_ctl,
    input  logic [DEPTH_W-1:0]  i_depth_raw,
    input  logic [PIX_W-1:0]    i_pixel_column,
    input  logic [PIX_W-1:0]    i_pixel_row,
    input  logic [RECIP_W-1:0]  i_inv_depth_scale,
    output logic [ZQ_W-1:0]     o_zq,
    output logic [Z_W-1:0]      o_point_z
);

    logic [ZFULL_W-1:0] r_zfull;
    logic               r_outside;
    logic [ZQ_W-1:0]    r_zq;
    logic [Z_W-1:0]     r_z3;
    logic [Z_W-1:0]     r_z4;
    logic [Z_W-1:0]     r_z5;
    logic               n_outside;
    logic [ZFULL_W-1:0] n_zround;
    logic [ZQ_W-1:0]    n_zq;

    assign n_outside = (LIMIT_W'(i_pixel_column) >= MAX_WIDTH_L) ||
                       (LIMIT_W'(i_pixel_row) >= MAX_HEIGHT_L);
    assign n_zround  = (r_zfull + ZQ_RND) >> ZQ_SHIFT;
    // Force depth to zero outside the frame so every coordinate collapses to the origin
    assign n_zq      = r_outside ? '0 : n_zround[ZQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_zfull   <= ZFULL_W'(i_depth_raw) * ZFULL_W'(i_inv_depth_scale);
            r_outside <= n_outside;
        end
        if (i_ctl.ld[1]) begin
            r_zq <= n_zq;
        end
        if (i_ctl.ld[2]) begin
            r_z3 <= r_zq[ZQ_W-1] ? Z_MAX : r_zq[Z_W-1:0];
        end
        if (i_ctl.ld[3]) begin
            r_z4 <= r_z3;
        end
        if (i_ctl.ld[4]) begin
            r_z5 <= r_z4;
        end
    end

    assign o_zq      = r_zq;
    assign o_point_z = r_z5;

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.ld[1] && r_outside) |=> (r_zq == '0))
        else $error("pixel outside frame kept a nonzero depth");

    a_sat_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.ld[2] && r_zq[ZQ_W-1]) |=> (r_z3 == Z_MAX))
        else $error("depth overflow not saturated");

    a_z_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld[4] |=> (r_z5 == $past(r_z4)))
        else $error("depth lost between last stages");

endmodule

// ----- hw/rtl/dpb_lateral.sv -----
module dpb_lateral
    import dpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pipe_ctl           i_ctl,
    input  logic [PIX_W-1:0]    i_pixel,
    input  logic [CENTER_W-1:0] i_center,
    input  logic [RECIP_W-1:0]  i_inv_focal,
    input  logic [ZQ_W-1:0]     i_zq,
    output logic [COORD_W-1:0]  o_coord
);

    logic [MAG_W-1:0]   r_mag1;
    logic [MAG_W-1:0]   r_mag2;
    logic [PROD_W-1:0]  r_prod;
    logic [PP_W-1:0]    r_pl;
    logic [PP_W-1:0]    r_ph;
    logic [COORD_W-1:0] r_coord;
    logic [NUM_STAGES-1:0] r_neg;

    logic [CENTER_W-1:0] n_pix_q4;
    logic                n_neg;
    logic [MAG_W-1:0]    n_mag;
    logic [SUM_W-1:0]    n_sum;
    logic [M_W-1:0]      n_m;
    logic [COORD_W-1:0]  n_coord;

    assign n_pix_q4 = {i_pixel, 4'b0000};
    assign n_neg    = n_pix_q4 < i_center;
    assign n_mag    = n_neg ? (i_center - n_pix_q4) : (n_pix_q4 - i_center);

    // Reassemble the two partial products and round the magnitude half away from zero
    assign n_sum = {r_ph, {HALF_W{1'b0}}} + SUM_W'(r_pl) + M_RND;
    assign n_m   = n_sum[SUM_W-1:28];

    always_comb begin
        if (r_neg[3]) begin
            n_coord = (n_m > M_NEG_LIM) ? COORD_NEG_MAX : (COORD_W'(0) - n_m[COORD_W-1:0]);
        end else begin
            n_coord = (n_m > M_POS_LIM) ? COORD_POS_MAX : n_m[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_mag1   <= n_mag;
            r_neg[0] <= n_neg;
        end
        if (i_ctl.ld[1]) begin
            r_mag2   <= r_mag1;
            r_neg[1] <= r_neg[0];
        end
        if (i_ctl.ld[2]) begin
            r_prod   <= PROD_W'(r_mag2) * PROD_W'(i_zq);
            r_neg[2] <= r_neg[1];
        end
        if (i_ctl.ld[3]) begin
            r_pl     <= PP_W'(r_prod[HALF_W-1:0]) * PP_W'(i_inv_focal);
            r_ph     <= PP_W'(r_prod[PROD_W-1:HALF_W]) * PP_W'(i_inv_focal);
            r_neg[3] <= r_neg[2];
        end
        if (i_ctl.ld[4]) begin
            r_coord  <= n_coord;
            r_neg[4] <= r_neg[3];
        end
    end

    assign o_coord = r_coord;

    // A nonzero coordinate carries the sign of its pixel offset
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld[4] |=> ((r_coord == '0) || (r_coord[COORD_W-1] == r_neg[4])))
        else $error("coordinate sign differs from pixel offset sign");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.ld[2] && (i_zq == '0)) |=> (r_prod == '0))
        else $error("zero depth gave a nonzero product");

    a_zero_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.ld[3] && (r_prod == '0)) |=> ((r_pl == '0) && (r_ph == '0)))
        else $error("zero product gave nonzero partial products");

endmodule

// ----- hw/rtl/depth_pixel_backprojection_top.sv -----
// Pinhole back-projection of depth pixels into 3D points. Each request on the
// input stream carries a 16-bit depth with its column and row and gives one
// point: z = depth * inv_depth_scale, x and y = (pixel - center) * z * inv_focal,
// all as Q16.16 metres saturated to 32 bits (z to 31). A zero depth or a pixel
// outside the frame gives the origin. The block takes one pixel every clock while
// the output is not stalled, and each point passes through a chain of depth
// multiply, rounding, offset multiply, two-part focal multiply and a final
// recombine-and-saturate stage.
// A stalled output backs up the pipeline stage by stage, filling bubbles first.
// Write the configuration registers only while no request is in flight.
module depth_pixel_backprojection_top
    import dpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] depth_raw, [27:16] pixel_column, [39:28] pixel_row
    input  logic [39:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [94:64] point_z, [95] zero
    output logic [95:0]           m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic [RECIP_W-1:0]  r_inv_fx;
    logic [RECIP_W-1:0]  r_inv_fy;
    logic [RECIP_W-1:0]  r_inv_scale;

    t_pipe_ctl           ctl;
    logic [DEPTH_W-1:0]  depth_raw;
    logic [PIX_W-1:0]    pixel_column;
    logic [PIX_W-1:0]    pixel_row;
    logic [ZQ_W-1:0]     zq;
    logic [COORD_W-1:0]  point_x;
    logic [COORD_W-1:0]  point_y;
    logic [Z_W-1:0]      point_z;

    assign depth_raw    = s_axis_tdata[15:0];
    assign pixel_column = s_axis_tdata[27:16];
    assign pixel_row    = s_axis_tdata[39:28];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= RST_CENTER_X;
            r_center_y  <= RST_CENTER_Y;
            r_inv_fx    <= RST_INV_FX;
            r_inv_fy    <= RST_INV_FY;
            r_inv_scale <= RST_INV_SCALE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CENTER_X:  r_center_x  <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data[CENTER_W-1:0];
                CFG_INV_FX:    r_inv_fx    <= i_cfg_data;
                CFG_INV_FY:    r_inv_fy    <= i_cfg_data;
                CFG_INV_SCALE: r_inv_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpb_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_ctl   (ctl)
    );

    dpb_depth u_depth (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_depth_raw       (depth_raw),
        .i_pixel_column    (pixel_column),
        .i_pixel_row       (pixel_row),
        .i_inv_depth_scale (r_inv_scale),
        .o_zq              (zq),
        .o_point_z         (point_z)
    );

    // x follows the column, y follows the row
    dpb_lateral u_lat_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_pixel     (pixel_column),
        .i_center    (r_center_x),
        .i_inv_focal (r_inv_fx),
        .i_zq        (zq),
        .o_coord     (point_x)
    );

    dpb_lateral u_lat_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_pixel     (pixel_row),
        .i_center    (r_center_y),
        .i_inv_focal (r_inv_fy),
        .i_zq        (zq),
        .o_coord     (point_y)
    );

    assign m_axis_tdata = {1'b0, point_z, point_y, point_x};

endmodule

// ----- tb/dpb_point_checker.sv -----
module dpb_point_checker
    import dpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [15:0] depth_raw, [27:16] pixel_column, [39:28] pixel_row
    input  logic [39:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [94:64] point_z, [95] zero
    input  logic [95:0]           m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [Z_W-1:0]     z;
    } t_point;

    logic [CENTER_W-1:0] center_x_q;
    logic [CENTER_W-1:0] center_y_q;
    logic [RECIP_W-1:0]  inv_fx_q;
    logic [RECIP_W-1:0]  inv_fy_q;
    logic [RECIP_W-1:0]  inv_scale_q;

    t_point expected_points[$];
    int     mismatches = 0;
    int     checked    = 0;

    // Signed offset from the principal point, scaled by depth and 1/f, rounded
    // half away from zero and clamped to the 32-bit range.
    function automatic logic [COORD_W-1:0] lateral_offset(
        input logic [PIX_W-1:0]    pixel,
        input logic [CENTER_W-1:0] center,
        input logic [63:0]         zq,
        input logic [RECIP_W-1:0]  inv_focal
    );
        logic [16:0]  pix_q4;
        logic [16:0]  mag;
        logic         neg;
        logic [127:0] prod;
        logic [127:0] m;
        pix_q4 = 17'(pixel) << 4;
        neg    = pix_q4 < 17'(center);
        mag    = neg ? 17'(center) - pix_q4 : pix_q4 - 17'(center);
        prod   = 128'(mag) * 128'(zq) * 128'(inv_focal) + (128'd1 << 27);
        m      = prod >> 28;
        if (neg) begin
            if (m > 128'h8000_0000)
                m = 128'h8000_0000;
            return COORD_W'(0) - m[COORD_W-1:0];
        end
        if (m > 128'h7FFF_FFFF)
            m = 128'h7FFF_FFFF;
        return m[COORD_W-1:0];
    endfunction

    function automatic t_point predict_point(
        input logic [DEPTH_W-1:0] depth,
        input logic [PIX_W-1:0]   col,
        input logic [PIX_W-1:0]   row
    );
        t_point      p;
        logic [63:0] zq;
        p = '0;
        if (int'(col) < MAX_WIDTH && int'(row) < MAX_HEIGHT) begin
            zq  = (64'(depth) * 64'(inv_scale_q) + (64'd1 << (ZQ_SHIFT - 1))) >> ZQ_SHIFT;
            p.x = lateral_offset(col, center_x_q, zq, inv_fx_q);
            p.y = lateral_offset(row, center_y_q, zq, inv_fy_q);
            p.z = (zq > 64'h7FFF_FFFF) ? {Z_W{1'b1}} : zq[Z_W-1:0];
        end
        return p;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            center_x_q  = RST_CENTER_X;
            center_y_q  = RST_CENTER_Y;
            inv_fx_q    = RST_INV_FX;
            inv_fy_q    = RST_INV_FY;
            inv_scale_q = RST_INV_SCALE;
            expected_points.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CENTER_X:  center_x_q  = i_cfg_data[CENTER_W-1:0];
                    CFG_CENTER_Y:  center_y_q  = i_cfg_data[CENTER_W-1:0];
                    CFG_INV_FX:    inv_fx_q    = i_cfg_data[RECIP_W-1:0];
                    CFG_INV_FY:    inv_fy_q    = i_cfg_data[RECIP_W-1:0];
                    CFG_INV_SCALE: inv_scale_q = i_cfg_data[RECIP_W-1:0];
                    default: ;
                endcase
            end
            // Retire before queuing so an early point cannot pass as expected
            if (m_axis_tvalid && m_axis_tready) begin
                got.x = m_axis_tdata[31:0];
                got.y = m_axis_tdata[63:32];
                got.z = m_axis_tdata[94:64];
                if (expected_points.size() == 0) begin
                    mismatches++;
                    $display("%0t: point with none expected, expected nothing, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_points.pop_front();
                    checked++;
                    check_field("point_x", want.x, got.x);
                    check_field("point_y", want.y, got.y);
                    check_field("point_z", 32'(want.z), 32'(got.z));
                    check_field("pad bit", 32'd0, 32'(m_axis_tdata[95]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_points = {expected_points, predict_point(s_axis_tdata[15:0],
                                                                  s_axis_tdata[27:16],
                                                                  s_axis_tdata[39:28])};
        end
        o_errors  <= mismatches;
        o_pending <= expected_points.size();
        o_checked <= checked;
    end

endmodule

// ----- tb/depth_pixel_backprojection_top_tb.sv -----
module depth_pixel_backprojection_top_tb;
    import dpb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 250000;
    localparam int BUSY_PCT       = 48;
    localparam int LIGHT_PCT      = 17;
    localparam int HOLD_CYCLES    = 120;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [95:0]           m_axis_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int mismatch_count;
    int pending_points;
    int checked_points;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int items_sent   = 0;
    int settings_run = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    depth_pixel_backprojection_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dpb_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatch_count),
        .o_pending     (pending_points),
        .o_checked     (checked_points)
    );

    // Output side: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [PIX_W-1:0] col,
                              input logic [PIX_W-1:0] row);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 40'({$urandom, $urandom});
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col, depth};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        case ($urandom_range(9))
            0:       depth = '0;
            1:       depth = '1;
            default: depth = DEPTH_W'($urandom);
        endcase
        send_pixel(depth, PIX_W'($urandom_range(4095)), PIX_W'($urandom_range(4095)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
    endtask

    // Drop the request and let the pipeline empty
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_points != 0)
            @(posedge i_clk);
        repeat (NUM_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                                 input logic [RECIP_W-1:0] fx, input logic [RECIP_W-1:0] fy,
                                 input logic [RECIP_W-1:0] scale);
        wait_idle();
        // Unmapped index first; it must leave every register alone
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
        write_reg(CFG_CENTER_X, {8'($urandom), cx});
        write_reg(CFG_CENTER_Y, {8'($urandom), cy});
        write_reg(CFG_INV_FX, fx);
        write_reg(CFG_INV_FY, fy);
        write_reg(CFG_INV_SCALE, scale);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [CENTER_W-1:0] pick_center();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return CENTER_W'($urandom);
            default: return CENTER_W'($urandom_range(4095 * 16));
        endcase
    endfunction

    function automatic logic [RECIP_W-1:0] pick_recip(input int lo, input int hi);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return RECIP_W'($urandom);
            default: return RECIP_W'($urandom_range(lo, hi));
        endcase
    endfunction

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("%0t: timeout, %0d points still outstanding", $time, pending_points);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int failures;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: origin, on-axis pixel, frame corners
        idle_pct  = LIGHT_PCT;
        stall_pct = LIGHT_PCT;
        send_pixel(16'd0,     12'd100,  12'd100);
        send_pixel(16'd1000,  12'd320,  12'd240);
        send_pixel(16'hFFFF,  12'hFFF,  12'hFFF);
        send_pixel(16'hFFFF,  12'd0,    12'd0);
        send_pixel(16'd1,     12'd0,    12'hFFF);
        send_pixel(16'h8000,  12'hAAA,  12'h555);
        send_pixel(16'h7FFF,  12'h555,  12'hAAA);
        send_pixel(16'd0,     12'hFFF,  12'd0);

        // Largest reciprocals: full-scale depth drives z and the off-centre coordinates into saturation
        apply_setting('0, '1, '1, '1, '1);
        send_pixel(16'hFFFF,  12'hFFF,  12'd0);
        send_pixel(16'hFFFF,  12'd0,    12'hFFF);
        send_pixel(16'd0,     12'hFFF,  12'hFFF);
        send_pixel(16'd1,     12'd0,    12'd0);
        send_pixel(16'd1,     12'hFFF,  12'hFFF);

        // Zero focal reciprocals flatten x and y
        apply_setting('1, '0, '0, '0, 24'd1);
        send_pixel(16'hFFFF,  12'd0,    12'hFFF);
        send_pixel(16'h1234,  12'hABC,  12'h123);

        // Zero depth scale collapses everything to the origin
        apply_setting(RST_CENTER_X, RST_CENTER_Y, RST_INV_FX, RST_INV_FY, '0);
        send_pixel(16'hFFFF,  12'hFFF,  12'hFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            apply_setting(pick_center(), pick_center(), pick_recip(1024, 131071),
                          pick_recip(1024, 131071), pick_recip(256, 65536));
            case (phase % 4)
                0: begin idle_pct = 0;         stall_pct = 0;         end
                1: begin idle_pct = BUSY_PCT;  stall_pct = 0;         end
                2: begin idle_pct = 0;         stall_pct = BUSY_PCT;  end
                default: begin idle_pct = LIGHT_PCT; stall_pct = LIGHT_PCT; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold the output while the input keeps pushing
                if (phase == 4 && n == 5)
                    hold_request = HOLD_CYCLES;
                send_random_pixel();
            end
        end

        wait_idle();
        repeat (NUM_STAGES * 4) @(posedge i_clk);
        failures = mismatch_count + pending_points;
        if (pending_points != 0)
            $display("%0t: %0d expected points never arrived", $time, pending_points);
        $display("Checked %0d points from %0d pixels over %0d register settings,",
                 checked_points, items_sent, settings_run + 1);
        $display("with input gaps, output stalls and one long output hold-off.");
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
